@@ rtl/sil_pkg.sv @@
// Shared types, command codes and helpers for the shared interrupt line table.
`default_nettype none
package sil_pkg;

    localparam int TAG_W = 32;
    localparam int CNT_W = 32;
    localparam int AFF_W = 64;
    localparam int TGT_W = 6;
    localparam int CMD_W = 3;
    localparam int LINE_W = 8;
    localparam int CLAIM_W = 4;

    localparam logic [CMD_W-1:0] CMD_REGISTER     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DISPATCH     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY        = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_AFFINITY = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PICK_TARGET  = 3'd5;

    localparam logic [2:0] REG_ROUTING = 3'd0;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic               line_ok;
        logic [LINE_W-1:0]  line;
        logic [TAG_W-1:0]   tag;
        logic               share;
        logic [CLAIM_W-1:0] claim;
        logic [AFF_W-1:0]   aff;
    } t_item;

    typedef struct packed {
        logic             status;
        logic             line_registered;
        logic [CNT_W-1:0] dispatch_total;
        logic [CNT_W-1:0] handled_total;
        logic [CNT_W-1:0] spurious_total;
        logic             claimed;
        logic [AFF_W-1:0] affinity_out;
        logic [TGT_W-1:0] dest_cpu;
    } t_rsp;

    function automatic logic [TGT_W-1:0] lowest_bit(input logic [AFF_W-1:0] m);
        logic [TGT_W-1:0] r;
        r = '0;
        for (int i = AFF_W - 1; i >= 0; i--) begin
            if (m[i]) r = TGT_W'(i);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/sil_if.sv @@
// Request and response channel interfaces of the shared interrupt line table.
`default_nettype none
interface sil_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  line;
    logic [31:0] device_tag;
    logic        share_request;
    logic [3:0]  claim_mask;
    logic [63:0] affinity_in;

    modport source(output valid, cmd, line, device_tag, share_request, claim_mask,
                   affinity_in, input ready);
    modport sink(input valid, cmd, line, device_tag, share_request, claim_mask,
                 affinity_in, output ready);
endinterface

interface sil_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        line_registered;
    logic [31:0] dispatch_total;
    logic [31:0] handled_total;
    logic [31:0] spurious_total;
    logic        claimed;
    logic [63:0] affinity_out;
    logic [5:0]  dest_cpu;

    modport source(output valid, status, line_registered, dispatch_total, handled_total,
                   spurious_total, claimed, affinity_out, dest_cpu, input ready);
    modport sink(input valid, status, line_registered, dispatch_total, handled_total,
                 spurious_total, claimed, affinity_out, dest_cpu, output ready);
endinterface
`default_nettype wire

@@ rtl/sil_front.sv @@
// Front end: accepts requests, checks the line range and queues them.
`default_nettype none
module sil_front
    import sil_pkg::*;
#(
    parameter int NUM_LINES = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sil_req_if.sink     i_req,
    output t_item       o_head,
    output logic        o_head_valid,
    input  wire         i_pop
);
    localparam int DEPTH = 2;

    t_item      r_q [DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_item      item;

    assign i_req.ready  = (r_cnt != 2'(DEPTH));
    assign push         = i_req.valid && i_req.ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];

    always_comb begin
        item.cmd     = i_req.cmd;
        item.line_ok = ({1'b0, i_req.line} < 9'(NUM_LINES));
        item.line    = i_req.line;
        item.tag     = i_req.device_tag;
        item.share   = i_req.share_request;
        item.claim   = i_req.claim_mask;
        item.aff     = i_req.affinity_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop && o_head_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop && o_head_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= item;
    end

endmodule
`default_nettype wire

@@ rtl/sil_back.sv @@
// Back end: line table memory, read-modify-write sequencer and result register.
`default_nettype none
module sil_back
    import sil_pkg::*;
#(
    parameter int NUM_LINES      = 256,
    parameter int SLOTS_PER_LINE = 4,
    parameter int TAG_BITS       = 32,
    parameter int COUNT_BITS     = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_routing,
    input  t_item       i_head,
    input  wire         i_head_valid,
    output logic        o_pop,
    sil_rsp_if.source   o_rsp
);
    localparam int LW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int SW = SLOTS_PER_LINE;
    localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int CW = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;

    typedef struct packed {
        logic [SW-1:0]         valid;
        logic                  shared;
        logic [CW-1:0]         disp;
        logic [CW-1:0]         hand;
        logic [CW-1:0]         spur;
        logic [AFF_W-1:0]      mask;
        logic [SW-1:0][TW-1:0] tag;
    } t_rec;

    typedef enum logic {ST_IDLE, ST_EXEC} t_state;

    t_rec           mem [NUM_LINES];
    logic [NUM_LINES-1:0] r_init;
    t_rec           r_rd;
    logic           r_rd_init;
    t_item          r_item;
    t_state         r_state;
    logic           r_out_valid;
    t_rsp           r_out;

    t_rec           cur, nxt;
    t_rsp           rsp;
    logic           fire, wr;
    logic           ok, claimed, hit, has_free;
    logic [2:0]     cnt, ncnt;
    logic [TW-1:0]  tag;
    logic [SW-1:0]  hit_oh, free_oh;
    logic [LW-1:0]  head_ln, ln;

    assign head_ln = i_head.line[LW-1:0];
    assign ln      = r_item.line[LW-1:0];
    assign o_pop   = (r_state == ST_IDLE) && i_head_valid;
    assign fire    = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);
    assign tag     = r_item.tag[TW-1:0];

    always_comb begin
        if (r_rd_init) begin
            cur = r_rd;
        end else begin
            cur        = '0;
            cur.mask   = '1;
        end
        cnt = '0;
        for (int s = 0; s < SW; s++) cnt = cnt + 3'(cur.valid[s]);
        // lowest matching and lowest free slot, one-hot
        hit_oh  = '0;
        free_oh = '0;
        for (int s = SW - 1; s >= 0; s--) begin
            if (cur.valid[s] && cur.tag[s] == tag) begin
                hit_oh    = '0;
                hit_oh[s] = 1'b1;
            end
            if (!cur.valid[s]) begin
                free_oh    = '0;
                free_oh[s] = 1'b1;
            end
        end
        hit      = |hit_oh;
        has_free = |free_oh;
        claimed  = 1'b0;
        ok       = 1'b0;
        wr       = 1'b0;
        nxt      = cur;
        ncnt     = cnt;
        unique case (r_item.cmd) inside
            CMD_REGISTER: begin
                ok = (tag != '0) && !(cnt != 3'd0 && (!cur.shared || !r_item.share))
                     && !hit && has_free;
                if (ok) begin
                    wr        = 1'b1;
                    nxt.valid = cur.valid | free_oh;
                    for (int s = 0; s < SW; s++) begin
                        if (free_oh[s]) nxt.tag[s] = tag;
                    end
                    nxt.shared = (cnt == 3'd0) ? r_item.share : (cur.shared | r_item.share);
                    ncnt = cnt + 3'd1;
                end
            end
            CMD_UNREGISTER: begin
                ok = (tag != '0) && hit;
                if (ok) begin
                    wr        = 1'b1;
                    nxt.valid = cur.valid & ~hit_oh;
                    ncnt      = cnt - 3'd1;
                    if (ncnt == 3'd0) nxt.shared = 1'b0;
                end
            end
            CMD_DISPATCH: begin
                ok       = 1'b1;
                wr       = 1'b1;
                claimed  = |(cur.valid & r_item.claim[SW-1:0]);
                nxt.disp = cur.disp + CW'(1);
                if (claimed) nxt.hand = cur.hand + CW'(1);
                else         nxt.spur = cur.spur + CW'(1);
            end
            CMD_QUERY, CMD_PICK_TARGET: ok = 1'b1;
            CMD_SET_AFFINITY: begin
                ok = i_routing && (r_item.aff != '0);
                if (ok) begin
                    wr       = 1'b1;
                    nxt.mask = r_item.aff;
                end
            end
            default: ok = 1'b0;
        endcase
        if (r_item.line_ok) begin
            rsp.status          = !ok;
            rsp.line_registered = (ncnt != 3'd0);
            rsp.dispatch_total  = CNT_W'(nxt.disp);
            rsp.handled_total   = CNT_W'(nxt.hand);
            rsp.spurious_total  = CNT_W'(nxt.spur);
            rsp.claimed         = claimed;
            rsp.affinity_out    = nxt.mask;
            rsp.dest_cpu        = lowest_bit(nxt.mask);
        end else begin
            rsp        = '0;
            rsp.status = 1'b1;
            wr         = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd      <= mem[head_ln];
            r_rd_init <= r_init[head_ln];
            r_item    <= i_head;
        end
        if (fire && wr) mem[ln] <= nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (fire && wr) begin
            r_init[ln] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_rsp.ready) r_out_valid <= 1'b0;
                    if (o_pop) r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (fire) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b1;
                        r_out       <= rsp;
                    end else if (o_rsp.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    if (o_rsp.ready) r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.line_registered = r_out.line_registered;
    assign o_rsp.dispatch_total  = r_out.dispatch_total;
    assign o_rsp.handled_total   = r_out.handled_total;
    assign o_rsp.spurious_total  = r_out.spurious_total;
    assign o_rsp.claimed         = r_out.claimed;
    assign o_rsp.affinity_out    = r_out.affinity_out;
    assign o_rsp.dest_cpu        = r_out.dest_cpu;

endmodule
`default_nettype wire

@@ rtl/shared_irq_line_table_unit.sv @@
// Top level of the shared interrupt line table: APB register, front end and back end.
`default_nettype none
// Keeps per-line handler slots, dispatch counters and CPU masks for up to
// NUM_LINES interrupt lines and answers each command with exactly one result.
// Requests enter a two-entry queue; for each command the back end first reads
// the line's entry from the single-port line table, then updates it and loads
// the result register, and it takes no new command from the queue until the
// current one is done. The update waits while an earlier result is still held
// in the result register. No clearing pass is needed after reset: untouched
// lines read as their reset contents. routing_enabled sits at byte address 0
// of the APB port and resets to 1.
module shared_irq_line_table_unit
    import sil_pkg::*;
#(
    parameter int NUM_LINES      = 256,
    parameter int SLOTS_PER_LINE = 4,
    parameter int TAG_BITS       = 32,
    parameter int COUNT_BITS     = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sil_req_if.sink     i_req,
    sil_rsp_if.source   o_rsp,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic  r_routing;
    t_item head;
    logic  head_valid, pop;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ROUTING) ? {31'd0, r_routing} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_routing <= 1'b1;
        end else if (psel && penable && pwrite && paddr == REG_ROUTING) begin
            r_routing <= pwdata[0];
        end
    end

    sil_front #(.NUM_LINES(NUM_LINES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    sil_back #(
        .NUM_LINES      (NUM_LINES),
        .SLOTS_PER_LINE (SLOTS_PER_LINE),
        .TAG_BITS       (TAG_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_routing    (r_routing),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_rsp        (o_rsp)
    );

`ifndef SYNTHESIS
    a_counts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.handled_total + o_rsp.spurious_total) == o_rsp.dispatch_total)
        else $error("handled plus spurious differs from dispatch count");
    a_target_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.affinity_out == 64'd0 || o_rsp.affinity_out[o_rsp.dest_cpu]))
        else $error("destination cpu not in mask");
    a_claim_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.claimed) |-> (o_rsp.line_registered && !o_rsp.status))
        else $error("claim on empty or rejected line");
`endif

endmodule
`default_nettype wire
